### rtl/core/cbe_pkg.sv
// Shared types and constants of the cubic Bezier evaluator pipeline.
// Used by every module of the core; depends on nothing else.
`default_nettype none

package cbe_pkg;

  // Pipeline depth: front, two multiply stages, sum stage, round/output stage
  localparam int unsigned CbeStages = 5;

  // Curve parameter value for 1.0 in Q0.16
  localparam logic [16:0] TOne = 17'h10000;

  // Accumulator widths for position (Q.48), velocity (Q.32), acceleration (Q.16)
  localparam int unsigned PosW = 88;
  localparam int unsigned VelW = 72;
  localparam int unsigned AccW = 60;

  // Half an output LSB at each accumulator scale: round to nearest, ties up
  localparam logic signed [PosW-1:0] PosHalf = PosW'(1) <<< 47;
  localparam logic signed [VelW-1:0] VelHalf = VelW'(1) <<< 31;
  localparam logic signed [AccW-1:0] AccHalf = AccW'(1) <<< 15;

  // Power-basis coefficients and powers of t, held after the front stage
  typedef struct packed {
    logic signed [31:0] a;   // P0
    logic signed [34:0] c1;  // 3(P1-P0)
    logic signed [35:0] c2;  // 3(P0-2P1+P2)
    logic signed [35:0] c3;  // P3-P0+3(P1-P2)
    logic        [16:0] t;
    logic        [32:0] t2;
  } cbe_coef_t;

  // Exact products, held after the second multiply stage
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [34:0] c1;
    logic signed [35:0] c2;
    logic signed [52:0] c1t;
    logic signed [53:0] c2t;
    logic signed [53:0] c3t;
    logic signed [69:0] c2t2;
    logic signed [69:0] c3t2;
    logic signed [60:0] c3t3_lo;
    logic signed [61:0] c3t3_hi;
  } cbe_prod_t;

endpackage

`default_nettype wire

### rtl/core/cbe_front.sv
// Front stage: saturate t, form power-basis coefficients and t squared.
// Depends on cbe_pkg.
`default_nettype none

module cbe_front
  import cbe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] ctrl_p0_i,
  input  wire logic signed [31:0] ctrl_p1_i,
  input  wire logic signed [31:0] ctrl_p2_i,
  input  wire logic signed [31:0] ctrl_p3_i,
  input  wire logic        [16:0] curve_param_i,
  output cbe_coef_t               coef_o
);

  cbe_coef_t          coef_d, coef_q;
  logic signed [32:0] d10, d12, d30;
  logic signed [34:0] k2;

  always_comb begin
    // clamp t to 1.0
    coef_d.t  = (curve_param_i > TOne) ? TOne : curve_param_i;
    coef_d.t2 = 33'(coef_d.t) * 33'(coef_d.t);
    d10       = 33'(ctrl_p1_i) - 33'(ctrl_p0_i);
    d12       = 33'(ctrl_p1_i) - 33'(ctrl_p2_i);
    d30       = 33'(ctrl_p3_i) - 33'(ctrl_p0_i);
    k2        = 35'(ctrl_p0_i) - (35'(ctrl_p1_i) <<< 1) + 35'(ctrl_p2_i);
    coef_d.a  = ctrl_p0_i;
    coef_d.c1 = (35'(d10) <<< 1) + 35'(d10);
    coef_d.c2 = (36'(k2) <<< 1) + 36'(k2);
    coef_d.c3 = 36'(d30) + (36'(d12) <<< 1) + 36'(d12);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

### rtl/core/cbe_mul.sv
// Two multiply stages: products with t, then with t squared and t cubed.
// Depends on cbe_pkg.
`default_nettype none

module cbe_mul
  import cbe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic [1:0] en_i,
  input  cbe_coef_t       coef_i,
  output cbe_prod_t       prod_o
);

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [34:0] c1;
    logic signed [35:0] c2;
    logic signed [35:0] c3;
    logic        [32:0] t2;
    logic        [48:0] t3;
    logic signed [52:0] c1t;
    logic signed [53:0] c2t;
    logic signed [53:0] c3t;
  } cbe_mid_t;

  cbe_mid_t           mid_d, mid_q;
  cbe_prod_t          prod_d, prod_q;
  logic signed [17:0] t_s;

  // first stage: everything that needs only t
  always_comb begin
    t_s       = $signed({1'b0, coef_i.t});
    mid_d.a   = coef_i.a;
    mid_d.c1  = coef_i.c1;
    mid_d.c2  = coef_i.c2;
    mid_d.c3  = coef_i.c3;
    mid_d.t2  = coef_i.t2;
    mid_d.t3  = 49'(coef_i.t2) * 49'(coef_i.t);
    mid_d.c1t = 53'(coef_i.c1) * 53'(t_s);
    mid_d.c2t = 54'(coef_i.c2) * 54'(t_s);
    mid_d.c3t = 54'(coef_i.c3) * 54'(t_s);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mid_q <= mid_d;
    end
  end

  // second stage: t cubed is split in two halves to keep each multiplier narrow
  always_comb begin
    prod_d.a       = mid_q.a;
    prod_d.c1      = mid_q.c1;
    prod_d.c2      = mid_q.c2;
    prod_d.c1t     = mid_q.c1t;
    prod_d.c2t     = mid_q.c2t;
    prod_d.c3t     = mid_q.c3t;
    prod_d.c2t2    = 70'(mid_q.c2) * 70'($signed({1'b0, mid_q.t2}));
    prod_d.c3t2    = 70'(mid_q.c3) * 70'($signed({1'b0, mid_q.t2}));
    prod_d.c3t3_lo = 61'(mid_q.c3) * 61'($signed({1'b0, mid_q.t3[23:0]}));
    prod_d.c3t3_hi = 62'(mid_q.c3) * 62'($signed({1'b0, mid_q.t3[48:24]}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/core/cbe_sum.sv
// Sum stages: partial sums with rounding offsets, then final add and scale.
// Depends on cbe_pkg.
`default_nettype none

module cbe_sum
  import cbe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic [1:0]         en_i,
  input  cbe_prod_t               prod_i,
  output logic signed [31:0]      position_o,
  output logic signed [34:0]      velocity_o,
  output logic signed [36:0]      acceleration_o
);

  logic signed [PosW-1:0] pos_a_d, pos_a_q, pos_b_d, pos_b_q, pos_sum;
  logic signed [VelW-1:0] vel_a_d, vel_a_q, vel_b_d, vel_b_q, vel_sum;
  logic signed [AccW-1:0] acc_d, acc_q;
  logic signed [31:0]     pos_d, pos_q;
  logic signed [34:0]     vel_d, vel_q;
  logic signed [36:0]     accel_d, accel_q;

  always_comb begin
    pos_a_d = (PosW'(prod_i.a) <<< 48) + (PosW'(prod_i.c1t) <<< 32) + PosHalf;
    pos_b_d = (PosW'(prod_i.c2t2) <<< 16) + (PosW'(prod_i.c3t3_hi) <<< 24)
            + PosW'(prod_i.c3t3_lo);
    vel_a_d = (VelW'(prod_i.c1) <<< 32) + (VelW'(prod_i.c2t) <<< 17) + VelHalf;
    vel_b_d = (VelW'(prod_i.c3t2) <<< 1) + VelW'(prod_i.c3t2);
    acc_d   = (AccW'(prod_i.c2) <<< 17) + (AccW'(prod_i.c3t) <<< 2)
            + (AccW'(prod_i.c3t) <<< 1) + AccHalf;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pos_a_q <= pos_a_d;
      pos_b_q <= pos_b_d;
      vel_a_q <= vel_a_d;
      vel_b_q <= vel_b_d;
      acc_q   <= acc_d;
    end
  end

  // drop the fractional bits; results are known to fit their outputs
  always_comb begin
    pos_sum = pos_a_q + pos_b_q;
    vel_sum = vel_a_q + vel_b_q;
    pos_d   = pos_sum[79:48];
    vel_d   = vel_sum[66:32];
    accel_d = acc_q[52:16];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pos_q   <= pos_d;
      vel_q   <= vel_d;
      accel_q <= accel_d;
    end
  end

  assign position_o     = pos_q;
  assign velocity_o     = vel_q;
  assign acceleration_o = accel_q;

endmodule

`default_nettype wire

### rtl/core/cubic_bezier_eval_core.sv
// Cubic Bezier evaluator: position, velocity and acceleration at t, one axis.
// Depends on cbe_pkg, cbe_front, cbe_mul and cbe_sum.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one transaction per axis:
//   four signed Q16.16 control coordinates and t in unsigned Q0.16; any t above
//   1.0 is clamped to 1.0. Output channel (out_valid_o / out_ready_i) returns
//   one transaction per input: position (Q16.16, 32 bits), velocity (35 bits)
//   and acceleration (37 bits), each rounded once to nearest, ties up.
//   Each transaction passes the front, two multiply stages, a sum stage and
//   the output register. Throughput is one transaction per cycle while the
//   receiver keeps out_ready_i high, set by the five-stage pipeline with one
//   multiplier rank per multiply stage.
//   Each stage holds a valid bit and advances when it is empty or when the
//   stage after it advances, so a stalled receiver freezes only the occupied
//   stages and bubbles close up; in_ready_o stays high while any stage is free.
//   Reset clears every valid bit; the block then holds no transaction.
`default_nettype none

module cubic_bezier_eval_core
  import cbe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] ctrl_p0_i,
  input  wire logic signed [31:0] ctrl_p1_i,
  input  wire logic signed [31:0] ctrl_p2_i,
  input  wire logic signed [31:0] ctrl_p3_i,
  input  wire logic        [16:0] curve_param_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      position_o,
  output logic signed [34:0]      velocity_o,
  output logic signed [36:0]      acceleration_o
);

  logic [CbeStages-1:0] vld_d, vld_q;
  logic [CbeStages-1:0] stage_en;
  cbe_coef_t            coef;
  cbe_prod_t            prod;
  logic                 in_fire, out_fire;

  // Stage enables: a stage loads when empty or when its content moves on.
  // Walk from the output back to the input.
  always_comb begin
    stage_en[CbeStages-1] = !vld_q[CbeStages-1] || out_ready_i;
    for (int i = CbeStages - 2; i >= 0; i--) begin
      stage_en[i] = !vld_q[i] || stage_en[i+1];
    end
  end

  // Valid bits travel with the data; hold them where the stage is frozen.
  always_comb begin
    vld_d = vld_q;
    if (stage_en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < CbeStages; i++) begin
      if (stage_en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = vld_q[CbeStages-1];
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // Front: clamp t, power-basis coefficients, t squared
  cbe_front u_front (
    .clk_i         (clk_i),
    .en_i          (stage_en[0]),
    .ctrl_p0_i     (ctrl_p0_i),
    .ctrl_p1_i     (ctrl_p1_i),
    .ctrl_p2_i     (ctrl_p2_i),
    .ctrl_p3_i     (ctrl_p3_i),
    .curve_param_i (curve_param_i),
    .coef_o        (coef)
  );

  // Exact products against powers of t
  cbe_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (stage_en[2:1]),
    .coef_i (coef),
    .prod_o (prod)
  );

  // Add up, round and register the results
  cbe_sum u_sum (
    .clk_i          (clk_i),
    .en_i           (stage_en[4:3]),
    .prod_i         (prod),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o)
  );

  // A receiver that is ready opens every stage, so the input is never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input refused while receiver ready");

  // Occupancy changes only by accepted and delivered transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> ($countones(vld_q) ==
                $past($countones(vld_q)) + $past(in_fire) - $past(out_fire)))
    else $error("transaction lost or duplicated in pipeline");

  // With the receiver ready, each accepted input reaches the output unstalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i |=> out_valid_o)
    else $error("result missing at expected latency");

endmodule

`default_nettype wire

### dv/tb_cubic_bezier_eval_core.sv
// Self-checking testbench for cubic_bezier_eval_core: position and derivatives at t.
// Depends on cbe_pkg and the core RTL; predicts each result from the Bezier formulae.
`timescale 1ns / 1ps

module tb_cubic_bezier_eval_core
  import cbe_pkg::*;
();

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned DrainCycles = 4 * CbeStages;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 10;

  localparam logic signed [31:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CoordMin = -32'sh8000_0000;

  // One axis of a segment plus its curve parameter
  typedef struct {
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] p3;
    logic        [16:0] t;
  } bezier_axis_t;

  // Position Q16.16, first derivative Q19.16, second derivative Q21.16
  typedef struct {
    logic signed [31:0] pos;
    logic signed [34:0] vel;
    logic signed [36:0] acc;
  } curve_sample_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] ctrl_p0_i     = '0;
  logic signed [31:0] ctrl_p1_i     = '0;
  logic signed [31:0] ctrl_p2_i     = '0;
  logic signed [31:0] ctrl_p3_i     = '0;
  logic        [16:0] curve_param_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic signed [31:0] position_o;
  logic signed [34:0] velocity_o;
  logic signed [36:0] acceleration_o;

  // Samples predicted for accepted transactions, oldest first
  curve_sample_t expected_samples[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatch_cnt   = 0;

  cubic_bezier_eval_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ctrl_p0_i      (ctrl_p0_i),
    .ctrl_p1_i      (ctrl_p1_i),
    .ctrl_p2_i      (ctrl_p2_i),
    .ctrl_p3_i      (ctrl_p3_i),
    .curve_param_i  (curve_param_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Abort a hung run; the limit sits far above the slowest legal run
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("cubic_bezier_eval_core verification failed");
    $finish;
  end

  // Evaluate one axis exactly in 128-bit arithmetic, then round once, ties up.
  // Bernstein form with u = 1 - t; parameters above one clamp to one.
  function automatic curve_sample_t eval_bezier_axis(bezier_axis_t ax);
    logic signed [127:0] a, b, c, d, t, u, sum;
    curve_sample_t s;
    a = ax.p0;
    b = ax.p1;
    c = ax.p2;
    d = ax.p3;
    t = (ax.t > TOne) ? TOne : ax.t;
    u = 128'sd65536 - t;

    // Position: weights in Q0.48
    sum = a * u * u * u + 3 * b * u * u * t + 3 * c * u * t * t + d * t * t * t;
    sum = (sum + (128'sd1 <<< 47)) >>> 48;
    s.pos = sum[31:0];

    // Velocity: weights in Q0.32
    sum = 3 * (b - a) * u * u + 6 * (c - b) * u * t + 3 * (d - c) * t * t;
    sum = (sum + (128'sd1 <<< 31)) >>> 32;
    s.vel = sum[34:0];

    // Acceleration: weights in Q0.16
    sum = 6 * (a - 2 * b + c) * u + 6 * (b - 2 * c + d) * t;
    sum = (sum + (128'sd1 <<< 15)) >>> 16;
    s.acc = sum[36:0];
    return s;
  endfunction

  // Offer one transaction; called at a rising edge, returns at the edge that accepts it.
  // Valid drops only during idle cycles before the item, never while it waits for ready.
  task automatic send_axis(bezier_axis_t ax);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    ctrl_p0_i     <= ax.p0;
    ctrl_p1_i     <= ax.p1;
    ctrl_p2_i     <= ax.p2;
    ctrl_p3_i     <= ax.p3;
    curve_param_i <= ax.t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_samples.push_back(eval_bezier_axis(ax));
  endtask

  task automatic send_fields(logic signed [31:0] p0, logic signed [31:0] p1,
                             logic signed [31:0] p2, logic signed [31:0] p3,
                             logic [16:0] t);
    bezier_axis_t ax;
    ax.p0 = p0;
    ax.p1 = p1;
    ax.p2 = p2;
    ax.p3 = p3;
    ax.t  = t;
    send_axis(ax);
  endtask

  // Coordinates: full range, realistic small values, or the extremes
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(3))
      0:       return $urandom_range(2097152) - 32'sd1048576;
      1: begin
        case ($urandom_range(3))
          0:       return CoordMax;
          1:       return CoordMin;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal t; some above one to exercise the clamp and the top bit
  function automatic logic [16:0] pick_param();
    case ($urandom_range(9))
      0:       return 17'($urandom_range(131071, 65537));
      1: begin
        case ($urandom_range(3))
          0:       return 17'd0;
          1:       return TOne;
          2:       return 17'd1;
          default: return 17'd65535;
        endcase
      end
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic send_random_axes(int unsigned n);
    bezier_axis_t ax;
    repeat (n) begin
      ax.p0 = pick_coord();
      ax.p1 = pick_coord();
      ax.p2 = pick_coord();
      ax.p3 = pick_coord();
      ax.t  = pick_param();
      send_axis(ax);
    end
  endtask

  task automatic report_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) $display("%0t: %s", $realtime, what);
  endtask

  // Compare each returned transaction against the oldest prediction
  task automatic check_sample();
    curve_sample_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch("result with nothing outstanding");
    end else begin
      want = expected_samples.pop_front();
      if (position_o !== want.pos)
        report_mismatch($sformatf("position exp %0d got %0d", want.pos, position_o));
      if (velocity_o !== want.vel)
        report_mismatch($sformatf("velocity exp %0d got %0d", want.vel, velocity_o));
      if (acceleration_o !== want.acc)
        report_mismatch($sformatf("acceleration exp %0d got %0d", want.acc,
                                  acceleration_o));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_sample();
  end

  // Receiver: honour a pending hold-off first, otherwise stall at the phase's rate
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left   <= hold_left - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Extremes, the clamp above one and rounding ties
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_fields(0, 0, 0, 0, 17'd0);
    send_fields(CoordMax, CoordMax, CoordMax, CoordMax, 17'd0);
    send_fields(CoordMax, CoordMax, CoordMax, CoordMax, TOne);
    send_fields(CoordMin, CoordMin, CoordMin, CoordMin, 17'd32768);
    // alternating extremes drive velocity and acceleration to their limits
    send_fields(CoordMin, CoordMax, CoordMin, CoordMax, 17'd0);
    send_fields(CoordMin, CoordMax, CoordMin, CoordMax, TOne);
    send_fields(CoordMin, CoordMax, CoordMin, CoordMax, 17'd32768);
    send_fields(CoordMax, CoordMin, CoordMax, CoordMin, 17'd0);
    send_fields(CoordMax, CoordMin, CoordMax, CoordMin, TOne);
    send_fields(CoordMin, CoordMax, CoordMax, CoordMin, 17'd32768);
    send_fields(CoordMax, CoordMin, CoordMin, CoordMax, 17'd16384);
    // parameter above one behaves as exactly one; values just inside the range follow
    send_fields(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'sh0004_0000,
                17'd65537);
    send_fields(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'sh0004_0000,
                17'h1FFFF);
    send_fields(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'sh0004_0000,
                17'd1);
    send_fields(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'sh0004_0000,
                17'd65535);
    // exact half-LSB ties at the midpoint round toward plus infinity
    send_fields(32'sd4, 0, 0, 0, 17'd32768);
    send_fields(-32'sd4, 0, 0, 0, 17'd32768);
    send_fields(0, 0, 0, 32'sd4, 17'd32768);
    send_fields(0, 0, 0, -32'sd4, 17'd32768);
    send_fields(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 17'd21845);
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                   int unsigned n);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_random_axes(n);
  endtask

  // Hold the receiver off long enough for the pipeline to fill and stall its input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 12 * CbeStages;
    send_random_axes(50);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(0, 0, 300);
    test_random_phase(61, 0, 300);
    test_random_phase(0, 61, 300);
    test_random_phase(7, 7, 350);
    test_backpressure();

    // Drop valid, let outstanding transactions drain, then settle
    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_samples.size() == 0) begin
      $display("cubic_bezier_eval_core verification clean");
    end else begin
      $display("cubic_bezier_eval_core verification failed");
    end
    $finish;
  end

endmodule

### cubic_bezier_eval_core.f
rtl/core/cbe_pkg.sv
rtl/core/cbe_front.sv
rtl/core/cbe_mul.sv
rtl/core/cbe_sum.sv
rtl/core/cubic_bezier_eval_core.sv
dv/tb_cubic_bezier_eval_core.sv
